/* rtl/teq_pkg.sv */
package teq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int CNT_BITS_DEF  = $clog2(DEPTH_DEF + 1);
  localparam int REF_BITS      = 16;
  localparam int ARG_BITS      = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

/* rtl/teq_if.sv */
interface teq_in_if #(
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  teq_pkg::cmd_t                 cmd;
  logic [TIME_BITS-1:0]          event_time;
  logic [teq_pkg::REF_BITS-1:0]  event_ref;
  logic [teq_pkg::ARG_BITS-1:0]  event_arg;

  modport source (output valid, cmd, event_time, event_ref, event_arg, input ready);
  modport sink   (input valid, cmd, event_time, event_ref, event_arg, output ready);
endinterface

interface teq_out_if #(
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
  parameter int CNT_BITS  = teq_pkg::CNT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          front_valid;
  logic [TIME_BITS-1:0]          front_time;
  logic [teq_pkg::REF_BITS-1:0]  front_ref;
  logic [teq_pkg::ARG_BITS-1:0]  front_arg;
  logic [CNT_BITS-1:0]           entry_count;
  logic                          push_dropped;

  modport source (output valid, front_valid, front_time, front_ref, front_arg,
                  entry_count, push_dropped, input ready);
  modport sink   (input valid, front_valid, front_time, front_ref, front_arg,
                  entry_count, push_dropped, output ready);
endinterface

/* rtl/teq_cell.sv */
module teq_cell #(
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  teq_pkg::cell_ctrl_t          ctrl,
  input  logic [TIME_BITS-1:0]         new_time,
  input  logic [teq_pkg::REF_BITS-1:0] new_ref,
  input  logic [teq_pkg::ARG_BITS-1:0] new_arg,
  input  logic                         prev_gt,
  input  logic                         prev_valid,
  input  logic [TIME_BITS-1:0]         prev_time,
  input  logic [teq_pkg::REF_BITS-1:0] prev_ref,
  input  logic [teq_pkg::ARG_BITS-1:0] prev_arg,
  input  logic                         next_valid,
  input  logic [TIME_BITS-1:0]         next_time,
  input  logic [teq_pkg::REF_BITS-1:0] next_ref,
  input  logic [teq_pkg::ARG_BITS-1:0] next_arg,
  output logic                         gt,
  output logic                         valid,
  output logic [TIME_BITS-1:0]         time_q,
  output logic [teq_pkg::REF_BITS-1:0] ref_q,
  output logic [teq_pkg::ARG_BITS-1:0] arg_q
);

  logic                         valid_r, valid_nxt;
  logic [TIME_BITS-1:0]         time_r, time_nxt;
  logic [teq_pkg::REF_BITS-1:0] ref_r, ref_nxt;
  logic [teq_pkg::ARG_BITS-1:0] arg_r, arg_nxt;

  // empty cells count as later than anything, keeping gt monotone along the row
  assign gt = !valid_r || (time_r > new_time);

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    ref_nxt   = ref_r;
    arg_nxt   = arg_r;
    if (ctrl.pop) begin
      valid_nxt = next_valid;
      time_nxt  = next_time;
      ref_nxt   = next_ref;
      arg_nxt   = next_arg;
    end else if (ctrl.push && gt) begin
      if (prev_gt) begin
        valid_nxt = prev_valid;
        time_nxt  = prev_time;
        ref_nxt   = prev_ref;
        arg_nxt   = prev_arg;
      end else begin
        valid_nxt = 1'b1;
        time_nxt  = new_time;
        ref_nxt   = new_ref;
        arg_nxt   = new_arg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    ref_r  <= ref_nxt;
    arg_r  <= arg_nxt;
  end

  assign valid  = valid_r;
  assign time_q = time_r;
  assign ref_q  = ref_r;
  assign arg_q  = arg_r;

endmodule

/* rtl/time_ordered_event_queue.sv */
// Time-ordered event queue. Holds up to DEPTH events sorted by ascending time
// in a row of cells; a push slots in behind every entry with an equal or
// earlier time, a pop takes the front. Each item on in_ch (cmd = push or pop)
// gives exactly one item on out_ch with the new front entry, its valid flag,
// the entry count and a flag set when a push met a full queue (that push is
// lost). Fronts read as zero when empty; a pop on an empty queue is a no-op.
// Rate: one item per clock. Every cell compares its own time against the
// pushed time and shifts in the same cycle, so the row itself never stalls;
// only back-pressure on the output register holds the input off. The result is
// registered and appears in the cycle after accept.
module time_ordered_event_queue #(
  parameter int DEPTH     = teq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = teq_pkg::TIME_BITS_DEF,
  parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
  input logic       clk,
  input logic       rst_n,
  teq_in_if.sink    in_ch,
  teq_out_if.source out_ch
);

  localparam int RB = teq_pkg::REF_BITS;
  localparam int AB = teq_pkg::ARG_BITS;

  // Cell row. Index DEPTH is a phantom empty cell past the tail; gt[0] is the
  // phantom "not greater" ahead of the head, so cell 0 takes the new item when its gt is set.
  logic                 c_valid [0:DEPTH];
  logic [TIME_BITS-1:0] c_time  [0:DEPTH];
  logic [RB-1:0]        c_ref   [0:DEPTH];
  logic [AB-1:0]        c_arg   [0:DEPTH];
  logic                 c_gt    [0:DEPTH];

  teq_pkg::cell_ctrl_t  ctrl;

  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 full;
  logic                 accept;
  logic                 is_push;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 fv_r, fv_nxt;
  logic [TIME_BITS-1:0] ft_r, ft_nxt;
  logic [RB-1:0]        fr_r, fr_nxt;
  logic [AB-1:0]        fa_r, fa_nxt;
  logic [CNT_BITS-1:0]  cnt_out_r;
  logic                 drop_r, drop_nxt;

  assign c_gt[0]       = 1'b0;
  assign c_valid[DEPTH] = 1'b0;
  assign c_time[DEPTH]  = '0;
  assign c_ref[DEPTH]   = '0;
  assign c_arg[DEPTH]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    teq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_time  (in_ch.event_time),
      .new_ref   (in_ch.event_ref),
      .new_arg   (in_ch.event_arg),
      .prev_gt   (c_gt[i]),
      .prev_valid(c_valid[P]),
      .prev_time (c_time[P]),
      .prev_ref  (c_ref[P]),
      .prev_arg  (c_arg[P]),
      .next_valid(c_valid[i+1]),
      .next_time (c_time[i+1]),
      .next_ref  (c_ref[i+1]),
      .next_arg  (c_arg[i+1]),
      .gt        (c_gt[i+1]),
      .valid     (c_valid[i]),
      .time_q    (c_time[i]),
      .ref_q     (c_ref[i]),
      .arg_q     (c_arg[i])
    );
  end

  // take a new item whenever the result slot is free or being emptied
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.cmd == teq_pkg::CMD_PUSH);
  assign full        = (count_r == CNT_BITS'(DEPTH));

  assign ctrl.push = accept && is_push && !full;
  assign ctrl.pop  = accept && !is_push && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  // Front after this item: a pop brings cell 1 forward, a push lands in cell 0
  // only when cell 0 is later than the new time (or empty).
  always_comb begin
    ft_nxt = c_time[0];
    fr_nxt = c_ref[0];
    fa_nxt = c_arg[0];
    if (ctrl.pop) begin
      ft_nxt = c_time[1];
      fr_nxt = c_ref[1];
      fa_nxt = c_arg[1];
    end else if (ctrl.push && c_gt[1]) begin
      ft_nxt = in_ch.event_time;
      fr_nxt = in_ch.event_ref;
      fa_nxt = in_ch.event_arg;
    end
    fv_nxt = (count_nxt != '0);
    if (!fv_nxt) begin
      ft_nxt = '0;
      fr_nxt = '0;
      fa_nxt = '0;
    end
    drop_nxt      = accept && is_push && full;
    out_valid_nxt = accept || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fv_r      <= fv_nxt;
      ft_r      <= ft_nxt;
      fr_r      <= fr_nxt;
      fa_r      <= fa_nxt;
      cnt_out_r <= count_nxt;
      drop_r    <= drop_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.front_valid  = fv_r;
  assign out_ch.front_time   = ft_r;
  assign out_ch.front_ref    = fr_r;
  assign out_ch.front_arg    = fa_r;
  assign out_ch.entry_count  = cnt_out_r;
  assign out_ch.push_dropped = drop_r;

  // count never runs past the row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("entry count beyond depth");

  // head cell occupancy tracks the count
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[0] == (count_r != '0))
    else $error("head cell valid disagrees with count");

  // tail cell occupancy tracks a full queue
  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[DEPTH-1] == full)
    else $error("tail cell valid disagrees with full");

  // a dropped push leaves the queue full and unchanged in size
  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_push && full) |=> (count_r == CNT_BITS'(DEPTH)))
    else $error("dropped push changed the count");

endmodule

/* bench/tb_time_ordered_event_queue.sv */
`timescale 1ns / 100ps

module tb_time_ordered_event_queue;

  localparam int QDEPTH   = teq_pkg::DEPTH_DEF;
  localparam int CNT_W    = $clog2(QDEPTH + 1);
  localparam int IDLE_PCT = 38;
  localparam int REF_BITS = teq_pkg::REF_BITS;
  localparam int ARG_BITS = teq_pkg::ARG_BITS;

  typedef teq_pkg::cmd_t cmd_t;

  // One reported front, laid out as the result channel carries it
  typedef struct packed {
    logic                 live;
    logic [31:0]          tstamp;
    logic [REF_BITS-1:0]  ident;
    logic [ARG_BITS-1:0]  arg;
    logic [CNT_W-1:0]     count;
    logic                 dropped;
  } front_t;

  // Directed row: repeated reps times, time stepping and ident counting up.
  // Rows with fixed_want set carry a hand-typed front instead of the predicted one.
  typedef struct {
    cmd_t                 cmd;
    logic [31:0]          t0;
    logic [31:0]          t_step;
    logic [REF_BITS-1:0]  ident0;
    logic [ARG_BITS-1:0]  arg;
    int                   reps;
    bit                   fixed_want;
    front_t               want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  teq_in_if  #(.TIME_BITS(teq_pkg::TIME_BITS_DEF))                   in_ch ();
  teq_out_if #(.TIME_BITS(teq_pkg::TIME_BITS_DEF), .CNT_BITS(CNT_W)) out_ch ();

  time_ordered_event_queue #(
    .DEPTH     (QDEPTH),
    .TIME_BITS (teq_pkg::TIME_BITS_DEF)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the sorted row, ascending time, equal times in arrival order
  logic [31:0]         sched_time  [QDEPTH];
  logic [REF_BITS-1:0] sched_ident [QDEPTH];
  logic [ARG_BITS-1:0] sched_arg   [QDEPTH];
  int                  sched_count;

  front_t pending_fronts [$];   // fronts still owed by the block, oldest first

  // Hand-typed expectation travelling with the item currently offered
  bit     fixed_now;
  front_t want_now;

  int idle_pct;
  int n_mismatch, n_checked, n_push, n_pop, n_dropped, n_empty_pop;

  stim_row_t directed_rows [9];

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = 1'b1;
      #2 clk = 1'b0;
    end
  end

  // Advance the shadow row by one command and return the front it leaves
  function automatic front_t schedule_step(cmd_t c, logic [31:0] t,
                                           logic [REF_BITS-1:0] id,
                                           logic [ARG_BITS-1:0] a);
    front_t f;
    int     pos;
    f = '0;
    if (c == teq_pkg::CMD_PUSH) begin
      if (sched_count >= QDEPTH) begin
        f.dropped = 1'b1;           // full: entry lost, row untouched
      end else begin
        // slot in behind every entry with an equal or earlier time
        pos = 0;
        while (pos < sched_count && sched_time[pos] <= t) pos++;
        for (int i = sched_count; i > pos; i--) begin
          sched_time[i]  = sched_time[i-1];
          sched_ident[i] = sched_ident[i-1];
          sched_arg[i]   = sched_arg[i-1];
        end
        sched_time[pos]  = t;
        sched_ident[pos] = id;
        sched_arg[pos]   = a;
        sched_count++;
      end
    end else if (sched_count > 0) begin
      for (int i = 1; i < sched_count; i++) begin
        sched_time[i-1]  = sched_time[i];
        sched_ident[i-1] = sched_ident[i];
        sched_arg[i-1]   = sched_arg[i];
      end
      sched_count--;
    end
    // empty row reads as all zero
    if (sched_count > 0) begin
      f.live   = 1'b1;
      f.tstamp = sched_time[0];
      f.ident  = sched_ident[0];
      f.arg    = sched_arg[0];
    end
    f.count = CNT_W'(sched_count);
    return f;
  endfunction

  // Offer one item: random idle cycles first, then hold until accepted.
  // Called and left at a falling edge.
  task automatic offer_item(cmd_t c, logic [31:0] t, logic [REF_BITS-1:0] id,
                            logic [ARG_BITS-1:0] a, bit fixed, front_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.event_time <= t;
    in_ch.event_ref  <= id;
    in_ch.event_arg  <= a;
    fixed_now        <= fixed;
    want_now         <= want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Input accepts feed the predictor; result accepts are checked against the
  // oldest owed front. Input handled first so a same-edge result still finds it.
  always @(posedge clk) begin : result_check
    front_t predicted;
    front_t seen;
    front_t owed;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == teq_pkg::CMD_PUSH) n_push++;
        else                                n_pop++;
        if (in_ch.cmd == teq_pkg::CMD_POP && sched_count == 0) n_empty_pop++;
        predicted = schedule_step(in_ch.cmd, in_ch.event_time, in_ch.event_ref,
                                  in_ch.event_arg);
        if (predicted.dropped) n_dropped++;
        pending_fronts.push_back(fixed_now ? want_now : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.live    = out_ch.front_valid;
        seen.tstamp  = out_ch.front_time;
        seen.ident   = out_ch.front_ref;
        seen.arg     = out_ch.front_arg;
        seen.count   = out_ch.entry_count;
        seen.dropped = out_ch.push_dropped;
        if (pending_fronts.size() == 0) begin
          if (n_mismatch < 10)
            $display("[%0t] result with nothing owed: live=%b t=%h id=%h arg=%h cnt=%0d drop=%b",
                     $realtime, seen.live, seen.tstamp, seen.ident, seen.arg,
                     seen.count, seen.dropped);
          n_mismatch++;
        end else begin
          owed = pending_fronts.pop_front();
          n_checked++;
          if (seen.live !== owed.live || seen.tstamp !== owed.tstamp ||
              seen.ident !== owed.ident || seen.arg !== owed.arg ||
              seen.count !== owed.count || seen.dropped !== owed.dropped) begin
            if (n_mismatch < 10) begin
              $display("[%0t] front mismatch on result %0d", $realtime, n_checked);
              $display("  exp live=%b t=%h id=%h arg=%h cnt=%0d drop=%b",
                       owed.live, owed.tstamp, owed.ident, owed.arg,
                       owed.count, owed.dropped);
              $display("  got live=%b t=%h id=%h arg=%h cnt=%0d drop=%b",
                       seen.live, seen.tstamp, seen.ident, seen.arg,
                       seen.count, seen.dropped);
            end
            n_mismatch++;
          end
        end
      end
    end
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    cmd_t        c;
    logic [31:0] t;
    int          push_pct;
    int          roll;
    int          push_mix [14];

    in_ch.valid      = 1'b0;
    in_ch.cmd        = teq_pkg::CMD_PUSH;
    in_ch.event_time = '0;
    in_ch.event_ref  = '0;
    in_ch.event_arg  = '0;
    out_ch.ready     = 1'b0;
    fixed_now        = 1'b0;
    want_now         = '0;
    idle_pct         = IDLE_PCT;
    sched_count      = 0;
    n_mismatch       = 0;
    n_checked        = 0;
    n_push           = 0;
    n_pop            = 0;
    n_dropped        = 0;
    n_empty_pop      = 0;

    // Directed: empty pop, field extremes, a tie on equal times, fill to the
    // brim with descending times, one push onto the full row, then a few pops.
    directed_rows = '{
      '{teq_pkg::CMD_POP,  32'h0,         32'h0,         16'h0000, 16'h0000, 1,  1'b1,
        '{1'b0, 32'h0,         16'h0000, 16'h0000, 5'd0,  1'b0}},
      '{teq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'h0,         16'hFFFF, 16'hFFFF, 1,  1'b1,
        '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 5'd1,  1'b0}},
      '{teq_pkg::CMD_PUSH, 32'h0,         32'h0,         16'h0000, 16'h0000, 1,  1'b1,
        '{1'b1, 32'h0,         16'h0000, 16'h0000, 5'd2,  1'b0}},
      // same time as the front: must queue behind it
      '{teq_pkg::CMD_PUSH, 32'h0,         32'h0,         16'h0001, 16'h0001, 1,  1'b0, '0},
      '{teq_pkg::CMD_POP,  32'h0,         32'h0,         16'h0000, 16'h0000, 1,  1'b0, '0},
      '{teq_pkg::CMD_PUSH, 32'h8000_0000, 32'h0,         16'hAAAA, 16'h5555, 1,  1'b0, '0},
      '{teq_pkg::CMD_PUSH, 32'hFFFF_0000, 32'hFFFF_FFF0, 16'h0100, 16'hF0F0, 13, 1'b0, '0},
      // row full: push lost, front still the surviving time-zero entry
      '{teq_pkg::CMD_PUSH, 32'h1,         32'h0,         16'h5555, 16'hAAAA, 1,  1'b1,
        '{1'b1, 32'h0,         16'h0001, 16'h0001, 5'd16, 1'b1}},
      '{teq_pkg::CMD_POP,  32'h0,         32'h0,         16'h0000, 16'h0000, 3,  1'b0, '0}
    };

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        offer_item(directed_rows[r].cmd,
                   directed_rows[r].t0 + directed_rows[r].t_step * 32'(k),
                   directed_rows[r].ident0 + REF_BITS'(k), directed_rows[r].arg,
                   directed_rows[r].fixed_want, directed_rows[r].want);
      end
    end

    // Random: blocks of 100 items, each with its own push/pop balance so the
    // row swings between brim-full and empty. Blocks 5 to 8 run with no idling.
    push_mix = '{85, 50, 20, 90, 60, 10, 75, 40, 95, 15, 55, 80, 30, 50};
    for (int blk = 0; blk < 14; blk++) begin
      push_pct = push_mix[blk];
      idle_pct = (blk >= 5 && blk <= 8) ? 0 : IDLE_PCT;
      for (int n = 0; n < 100; n++) begin
        c    = ($urandom_range(99) < push_pct) ? teq_pkg::CMD_PUSH : teq_pkg::CMD_POP;
        roll = $urandom_range(19);
        // narrow time range gives plenty of ties
        if (roll < 2)       t = 32'h0;
        else if (roll < 4)  t = 32'hFFFF_FFFF;
        else if (roll < 12) t = 32'($urandom_range(15));
        else                t = $urandom;
        offer_item(c, t, REF_BITS'($urandom), ARG_BITS'($urandom), 1'b0, '0);
      end
    end
    idle_pct    = IDLE_PCT;
    in_ch.valid <= 1'b0;

    while (pending_fronts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items in (%0d push, %0d pop), %0d results checked",
             n_push + n_pop, n_push, n_pop, n_checked);
    $display("%0d pushes lost to a full row, %0d pops on an empty row, %0d mismatches",
             n_dropped, n_empty_pop, n_mismatch);
    if (n_mismatch == 0 && pending_fronts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
